// File: hw/rtl/rpg_pkg.sv
// Shared types, codes and constants of the relocation patch generator.
`timescale 1ns / 1ps
`default_nettype none

package rpg_pkg;

   // Image layout.
   localparam logic [31:0] HEADER_BYTES = 32'd52;
   localparam logic [31:0] LA32_LOW_STEP = 32'd4;
   localparam logic [31:0] HALF_MASK = 32'h0000_FFFF;
   localparam int unsigned HALF_SHIFT = 16;

   // Relocation types as they arrive.
   localparam logic [3:0] RELOC_BRANCH28 = 4'd0;
   localparam logic [3:0] RELOC_PTR32 = 4'd1;
   localparam logic [3:0] RELOC_LA32 = 4'd2;

   // Segment codes.
   localparam logic [3:0] SEG_TEXT = 4'd0;
   localparam logic [3:0] SEG_RODATA = 4'd1;
   localparam logic [3:0] SEG_DATA = 4'd2;
   localparam logic [3:0] SEG_BSS = 4'd3;
   localparam logic [3:0] SEG_EXTERN = 4'd4;

   // Result kinds.
   localparam logic [1:0] RK_W32 = 2'd0;
   localparam logic [1:0] RK_W16 = 2'd1;
   localparam logic [1:0] RK_BRANCH = 2'd2;
   localparam logic [1:0] RK_BAD = 2'd3;

   // Register indexes of the configuration port.
   localparam int unsigned CSR_INDEX_W = 3;
   localparam logic [CSR_INDEX_W-1:0] CSR_TEXT_BYTES = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_RODATA_BYTES = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_DATA_BYTES = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_RO_BASE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_RW_BASE = 3'd4;

   // Queue between front and back.
   localparam int unsigned QUEUE_DEPTH = 4;
   localparam int unsigned QUEUE_AW = $clog2(QUEUE_DEPTH);

   // What the back has to do for one entry.
   typedef enum logic [1:0] {
      OP_W32,
      OP_LA32,
      OP_BRANCH,
      OP_BAD
   } op_type;

   // Configuration as the datapath sees it; sizes are already rounded.
   typedef struct packed {
      logic [31:0] text_rnd;
      logic [31:0] rodata_rnd;
      logic [31:0] data_rnd;
      logic [31:0] ro_base;
      logic [31:0] rw_base;
   } cfg_type;

   // One classified entry waiting for the back.
   typedef struct packed {
      op_type      op;
      logic [31:0] target;
      logic [31:0] loc;
   } entry_type;

   // Queue status seen by both sides.
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   function automatic logic [31:0] round4(input logic [31:0] n);
      round4 = (n + 32'd3) & ~32'd3;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rpg_front.sv
// Front part: accepts relocation entries, classifies them and computes addresses.
`timescale 1ns / 1ps
`default_nettype none

module rpg_front
   import rpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [3:0]  req_reloc_kind,
   input  wire logic [3:0]  req_src_segment,
   input  wire logic [3:0]  req_dst_segment,
   input  wire logic [31:0] req_src_offset,
   input  wire logic [31:0] req_dst_offset,
   input  wire cfg_type     cfg,
   input  wire qstat_type   qstat,
   output logic             push,
   output entry_type        push_entry
);

   logic advance;
   logic accept;
   logic keep_in;
   op_type op_in;

   // Stage 1 registers.
   logic        s1_valid_ff;
   op_type      s1_op_ff;
   logic [1:0]  s1_src_ff;
   logic [1:0]  s1_dst_ff;
   logic [31:0] s1_soff_ff;
   logic [31:0] s1_doff_ff;
   logic [31:0] s1_doff_rd_ff;
   logic [31:0] s1_a1_ff;
   logic [31:0] s1_i1_ff;
   logic [31:0] s1_rrd_ff;

   // Stage 2 registers.
   logic        s2_valid_ff;
   op_type      s2_op_ff;
   logic [1:0]  s2_src_ff;
   logic [1:0]  s2_dst_ff;
   logic [31:0] s2_soff_ff;
   logic [31:0] s2_doff_ff;
   logic [31:0] s2_doff_rd_ff;
   logic [31:0] s2_a1_ff;
   logic [31:0] s2_a2_ff;
   logic [31:0] s2_i1_ff;
   logic [31:0] s2_i2_ff;
   logic [31:0] s2_i3_ff;

   // Stage 3 registers.
   logic        s3_valid_ff;
   op_type      s3_op_ff;
   logic [31:0] s3_target_ff;
   logic [31:0] s3_loc_ff;

   logic [31:0] a2_in;
   logic [31:0] tbase_in;
   logic [31:0] taddend_in;
   logic [31:0] lbase_in;

   // The whole pipeline moves together unless its last stage cannot enter the queue.
   assign advance   = !s3_valid_ff || !qstat.full;
   assign req_stall = !advance;
   assign accept    = req_valid && advance;
   assign push      = s3_valid_ff && !qstat.full;
   assign push_entry = '{op: s3_op_ff, target: s3_target_ff, loc: s3_loc_ff};

   // External targets are dropped here and never reach the queue.
   always_comb begin
      keep_in = (req_dst_segment != SEG_EXTERN);
      if (req_reloc_kind > RELOC_LA32) begin
         op_in = OP_BAD;
      end else if (req_reloc_kind == RELOC_BRANCH28) begin
         op_in = OP_BRANCH;
      end else if ((req_src_segment > SEG_BSS) || (req_dst_segment > SEG_EXTERN)) begin
         op_in = OP_BAD;
      end else if (req_reloc_kind == RELOC_PTR32) begin
         op_in = OP_W32;
      end else begin
         op_in = OP_LA32;
      end
   end

   always_comb begin
      a2_in = (cfg.rw_base != 32'd0) ? cfg.rw_base : (s1_a1_ff + cfg.rodata_rnd);

      case (s2_dst_ff)
         SEG_TEXT[1:0]:   tbase_in = cfg.ro_base;
         SEG_RODATA[1:0]: tbase_in = s2_a1_ff;
         default:         tbase_in = s2_a2_ff;
      endcase
      taddend_in = (s2_dst_ff == SEG_BSS[1:0]) ? s2_doff_rd_ff : s2_doff_ff;

      case (s2_src_ff)
         SEG_TEXT[1:0]:   lbase_in = HEADER_BYTES;
         SEG_RODATA[1:0]: lbase_in = s2_i1_ff;
         SEG_DATA[1:0]:   lbase_in = s2_i2_ff;
         default:         lbase_in = s2_i3_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else if (advance) begin
         s1_valid_ff <= accept && keep_in;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_op_ff      <= op_in;
         s1_src_ff     <= req_src_segment[1:0];
         s1_dst_ff     <= req_dst_segment[1:0];
         s1_soff_ff    <= req_src_offset;
         s1_doff_ff    <= req_dst_offset;
         s1_doff_rd_ff <= req_dst_offset + cfg.data_rnd;
         s1_a1_ff      <= cfg.ro_base + cfg.text_rnd;
         s1_i1_ff      <= HEADER_BYTES + cfg.text_rnd;
         s1_rrd_ff     <= cfg.rodata_rnd + cfg.data_rnd;

         s2_op_ff      <= s1_op_ff;
         s2_src_ff     <= s1_src_ff;
         s2_dst_ff     <= s1_dst_ff;
         s2_soff_ff    <= s1_soff_ff;
         s2_doff_ff    <= s1_doff_ff;
         s2_doff_rd_ff <= s1_doff_rd_ff;
         s2_a1_ff      <= s1_a1_ff;
         s2_a2_ff      <= a2_in;
         s2_i1_ff      <= s1_i1_ff;
         s2_i2_ff      <= s1_i1_ff + cfg.rodata_rnd;
         s2_i3_ff      <= s1_i1_ff + s1_rrd_ff;

         s3_op_ff      <= s2_op_ff;
         s3_target_ff  <= tbase_in + taddend_in;
         s3_loc_ff     <= lbase_in + s2_soff_ff;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rpg_queue.sv
// Short queue of classified entries between the front and the back.
`timescale 1ns / 1ps
`default_nettype none

module rpg_queue
   import rpg_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire entry_type push_entry,
   input  wire logic      pop,
   output entry_type      pop_entry,
   output qstat_type      qstat
);

   entry_type            slots_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]  wr_ptr_ff;
   logic [QUEUE_AW-1:0]  rd_ptr_ff;
   logic [QUEUE_AW:0]    count_ff;
   logic [QUEUE_AW:0]    count_in;

   assign qstat.full  = (count_ff == (QUEUE_AW+1)'(QUEUE_DEPTH));
   assign qstat.empty = (count_ff == '0);
   assign pop_entry   = slots_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

`default_nettype wire

// File: hw/rtl/rpg_back.sv
// Back part: turns queued entries into result transfers.
`timescale 1ns / 1ps
`default_nettype none

module rpg_back
   import rpg_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire qstat_type   qstat,
   input  wire entry_type   pop_entry,
   output logic             pop,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic [1:0]       rsp_result_kind,
   output logic [31:0]      rsp_image_offset,
   output logic [31:0]      rsp_write_data,
   output logic             rsp_last
);

   logic        rsp_valid_ff;
   logic        rsp_valid_in;
   logic        low_pend_ff;
   logic        low_pend_in;
   logic [1:0]  kind_ff;
   logic [1:0]  kind_in;
   logic [31:0] offset_ff;
   logic [31:0] offset_in;
   logic [31:0] data_ff;
   logic [31:0] data_in;
   logic        last_ff;
   logic        last_in;
   logic [31:0] low_loc_ff;
   logic [31:0] low_loc_in;
   logic [31:0] low_data_ff;
   logic [31:0] low_data_in;
   logic        load;

   // The output register takes a new result when empty or when its result is taken.
   assign load = !rsp_valid_ff || !rsp_stall;
   assign pop  = load && !low_pend_ff && !qstat.empty;

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_kind  = kind_ff;
   assign rsp_image_offset = offset_ff;
   assign rsp_write_data   = data_ff;
   assign rsp_last         = last_ff;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      low_pend_in  = low_pend_ff;
      kind_in      = kind_ff;
      offset_in    = offset_ff;
      data_in      = data_ff;
      last_in      = last_ff;
      low_loc_in   = low_loc_ff;
      low_data_in  = low_data_ff;
      if (load) begin
         if (low_pend_ff) begin
            rsp_valid_in = 1'b1;
            low_pend_in  = 1'b0;
            kind_in      = RK_W16;
            offset_in    = low_loc_ff;
            data_in      = low_data_ff;
            last_in      = 1'b1;
         end else if (!qstat.empty) begin
            rsp_valid_in = 1'b1;
            case (pop_entry.op)
               OP_W32: begin
                  kind_in   = RK_W32;
                  offset_in = pop_entry.loc;
                  data_in   = pop_entry.target;
                  last_in   = 1'b1;
               end
               OP_LA32: begin
                  low_pend_in = 1'b1;
                  kind_in     = RK_W16;
                  offset_in   = pop_entry.loc;
                  data_in     = (pop_entry.target >> HALF_SHIFT) & HALF_MASK;
                  last_in     = 1'b0;
                  low_loc_in  = pop_entry.loc + LA32_LOW_STEP;
                  low_data_in = pop_entry.target & HALF_MASK;
               end
               OP_BRANCH: begin
                  kind_in   = RK_BRANCH;
                  offset_in = 32'd0;
                  data_in   = 32'd0;
                  last_in   = 1'b1;
               end
               default: begin
                  kind_in   = RK_BAD;
                  offset_in = 32'd0;
                  data_in   = 32'd0;
                  last_in   = 1'b1;
               end
            endcase
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         low_pend_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         low_pend_ff  <= low_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      offset_ff   <= offset_in;
      data_ff     <= data_in;
      last_ff     <= last_in;
      low_loc_ff  <= low_loc_in;
      low_data_ff <= low_data_in;
   end

   // While the low half waits, the high half of the same entry is on the output.
   a_pend_shows_high: assert property (@(posedge clock) disable iff (reset)
      low_pend_ff |-> (rsp_valid_ff && (kind_ff == RK_W16) && !last_ff))
      else $error("low half pending without its high half on the output");

   // A result that is not the last of its entry always has a follow-up pending.
   a_not_last_pend: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !last_ff) |-> low_pend_ff)
      else $error("non-final result without a pending low half");

   // No new entry is taken while an entry's low half is still owed.
   a_no_pop_while_pend: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!low_pend_ff && !qstat.empty))
      else $error("entry taken from the queue while a low half is owed");

endmodule

`default_nettype wire

// File: hw/rtl/relocation_patch_generator_top.sv
// Top level of the relocation patch generator: configuration registers and datapath.
`timescale 1ns / 1ps
`default_nettype none

// Usage. Relocation entries arrive on the req_ channel and are taken at a rising
// edge with req_valid high and req_stall low. Patch results leave on the rsp_
// channel under the same valid/stall rule; every transfer carries a result kind,
// an image offset, the data to write and a last flag that closes the entry.
// A pointer entry gives one 32-bit write, a load-address entry gives two 16-bit
// writes (high half first), an external target gives nothing, and a branch or a
// malformed entry gives a single notice.
// The user is to write segment sizes and load bases through the csr_ port only
// while no entry is in flight; the block itself does not enforce this. Sizes are
// rounded up to whole words as they are written. A three-stage address pipeline
// (one adder deep per stage) feeds a four-entry queue, and the back end puts out
// one result per cycle while the receiver does not stall, so entries flow at one
// per cycle for single-result kinds; no new entry is taken while a load-address
// entry's low half is owed; the back end's single output register sets that rate.
// When the receiver stalls, the output holds, the queue fills, and only then does
// req_stall rise. Reset is synchronous: it empties pipeline, queue and output and
// clears all configuration registers to zero.
module relocation_patch_generator_top
   import rpg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [31:0]            csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire logic [3:0]             req_reloc_kind,
   input  wire logic [3:0]             req_src_segment,
   input  wire logic [3:0]             req_dst_segment,
   input  wire logic [31:0]            req_src_offset,
   input  wire logic [31:0]            req_dst_offset,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [1:0]                  rsp_result_kind,
   output logic [31:0]                 rsp_image_offset,
   output logic [31:0]                 rsp_write_data,
   output logic                        rsp_last
);

   cfg_type   cfg_ff;
   qstat_type qstat;
   logic      push;
   logic      pop;
   entry_type push_entry;
   entry_type pop_entry;

   // Sizes are stored already rounded, so the datapath never rounds per entry.
   // Writes to indexes beyond the register list are dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_TEXT_BYTES:   cfg_ff.text_rnd   <= round4(csr_wdata);
            CSR_RODATA_BYTES: cfg_ff.rodata_rnd <= round4(csr_wdata);
            CSR_DATA_BYTES:   cfg_ff.data_rnd   <= round4(csr_wdata);
            CSR_RO_BASE:      cfg_ff.ro_base    <= csr_wdata;
            CSR_RW_BASE:      cfg_ff.rw_base    <= csr_wdata;
            default:          cfg_ff            <= cfg_ff;
         endcase
      end
   end

   rpg_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_reloc_kind  (req_reloc_kind),
      .req_src_segment (req_src_segment),
      .req_dst_segment (req_dst_segment),
      .req_src_offset  (req_src_offset),
      .req_dst_offset  (req_dst_offset),
      .cfg             (cfg_ff),
      .qstat           (qstat),
      .push            (push),
      .push_entry      (push_entry)
   );

   rpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .qstat      (qstat)
   );

   rpg_back u_back (
      .clock            (clock),
      .reset            (reset),
      .qstat            (qstat),
      .pop_entry        (pop_entry),
      .pop              (pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_result_kind  (rsp_result_kind),
      .rsp_image_offset (rsp_image_offset),
      .rsp_write_data   (rsp_write_data),
      .rsp_last         (rsp_last)
   );

endmodule

`default_nettype wire
